// File: rtl/core/ecsm_pkg.sv
// ecsm_pkg: shared widths, opcodes and types for the EC scalar multiplier.
// No dependencies.
package ecsm_pkg;
  localparam int FieldBits  = 31;
  localparam int ScalarBits = 32;
  localparam int CntBits    = 6;

  localparam logic [2:0] RegModulus = 3'd0;
  localparam logic [2:0] RegCoefA   = 3'd4;

  typedef logic [FieldBits-1:0] fe_t;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MOD = 3'd3,
    OP_DIV = 3'd4
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;
endpackage

// File: rtl/core/ecsm_alu.sv
// ecsm_alu: shared iterative field unit (mul, add, sub, reduce, divide).
// Depends on ecsm_pkg. Mul, divide and reduce run one bit per cycle.
module ecsm_alu (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ecsm_pkg::alu_ctl_t       ctl_i,
  input  ecsm_pkg::fe_t            p_i,
  input  logic [ecsm_pkg::FieldBits:0] u_i,
  input  logic [ecsm_pkg::FieldBits:0] v_i,
  output ecsm_pkg::alu_sts_t       sts_o,
  output ecsm_pkg::fe_t            res_o,
  output ecsm_pkg::fe_t            rem_o
);
  import ecsm_pkg::*;

  logic                 busy_q, busy_d, done_q, done_d;
  alu_op_e              op_q, op_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [FieldBits:0]   a_q, a_d, b_q, b_d;
  logic [FieldBits:0]   r_q, r_d, q_q, q_d;
  logic [FieldBits+1:0] dbl, dbl2, s;
  logic [FieldBits+1:0] rsh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    q_d    = q_q;
    dbl    = {r_q, 1'b0};
    if (dbl >= {2'b0, p_i}) dbl = dbl - {2'b0, p_i};
    dbl2   = dbl + {1'b0, a_q};
    if (dbl2 >= {2'b0, p_i}) dbl2 = dbl2 - {2'b0, p_i};
    rsh    = {r_q, a_q[cnt_q[CntBits-2:0]]};
    s      = '0;
    if (ctl_i.start) begin
      op_d = ctl_i.op;
      a_d  = u_i;
      b_d  = v_i;
      r_d  = '0;
      q_d  = '0;
      cnt_d = CntBits'(FieldBits);
      case (ctl_i.op)
        OP_ADD: begin
          s = {1'b0, u_i} + {1'b0, v_i};
          if (s >= {2'b0, p_i}) s = s - {2'b0, p_i};
          r_d = s[FieldBits:0];
          done_d = 1'b1;
        end
        OP_SUB: begin
          s = (u_i >= v_i) ? {1'b0, u_i} - {1'b0, v_i}
                           : {1'b0, u_i} + ({2'b0, p_i} - {1'b0, v_i});
          r_d = s[FieldBits:0];
          done_d = 1'b1;
        end
        OP_MOD, OP_DIV, OP_MUL: busy_d = 1'b1;
        default: done_d = 1'b1;
      endcase
      if (ctl_i.op == OP_MOD) b_d = {1'b0, p_i};
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          r_d = b_q[cnt_q[CntBits-2:0]] ? dbl2[FieldBits:0] : dbl[FieldBits:0];
        end
        default: begin
          q_d = {q_q[FieldBits-1:0], 1'b0};
          if (rsh >= {1'b0, b_q}) begin
            r_d = rsh[FieldBits:0] - b_q;
            q_d[0] = 1'b1;
          end else begin
            r_d = rsh[FieldBits:0];
          end
        end
      endcase
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_ADD;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
    q_q <= q_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o = (op_q == OP_DIV) ? q_q[FieldBits-1:0] : r_q[FieldBits-1:0];
  assign rem_o = r_q[FieldBits-1:0];
endmodule

// File: rtl/core/ecsm_seq.sv
// ecsm_seq: sequencer for double-and-add, point add/double and inverse.
// Depends on ecsm_pkg and drives one ecsm_alu.
module ecsm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 ack_i,
  input  ecsm_pkg::fe_t        p_i,
  input  ecsm_pkg::fe_t        a_i,
  input  ecsm_pkg::fe_t        x_i,
  input  ecsm_pkg::fe_t        y_i,
  input  logic                 inf_i,
  input  logic [ecsm_pkg::ScalarBits-1:0] k_i,
  output logic                 busy_o,
  output logic                 done_o,
  output ecsm_pkg::fe_t        x_o,
  output ecsm_pkg::fe_t        y_o,
  output logic                 inf_o
);
  import ecsm_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0,  S_RA = 6'd1,  S_RX = 6'd2,  S_RY = 6'd3,
    S_LOOP = 6'd4, S_SEL = 6'd5, S_DBL1 = 6'd6, S_DBL2 = 6'd7, S_DBL3 = 6'd8,
    S_DBL4 = 6'd9, S_ADD1 = 6'd10, S_ADD2 = 6'd11, S_INV0 = 6'd12,
    S_INVQ = 6'd13, S_INVR = 6'd14, S_INVM = 6'd15, S_INVS = 6'd16,
    S_LAM = 6'd17, S_X1 = 6'd18, S_X2 = 6'd19, S_X3 = 6'd20, S_Y1 = 6'd21,
    S_Y2 = 6'd22, S_Y3 = 6'd23, S_STORE = 6'd24, S_NEXT = 6'd25,
    S_DONE = 6'd26;

  logic [5:0] st_q, st_d;
  logic       wait_q, wait_d;
  logic       phase_q, phase_d;
  fe_t        ca_q, ca_d;
  fe_t        ax_q, ax_d, ay_q, ay_d, rx_q, rx_d, ry_q, ry_d;
  logic       ainf_q, ainf_d, rinf_q, rinf_d;
  logic [ScalarBits-1:0] k_q, k_d;
  fe_t        sx_q, sx_d, sy_q, sy_d, tx_q, tx_d, ty_q, ty_d;
  fe_t        num_q, num_d, den_q, den_d, lam_q, lam_d, t0_q, t0_d, nx_q, nx_d;
  fe_t        w0_q, w0_d, w1_q, w1_d, w2_q, w2_d, w3_q, w3_d, qq_q, qq_d, rr_q, rr_d;
  alu_ctl_t   ctl;
  alu_sts_t   sts;
  logic [FieldBits:0] u, v;
  fe_t        res, rem;
  fe_t        p3;
  logic       go;

  ecsm_alu u_alu (
    .clk_i, .rst_ni, .ctl_i(ctl), .p_i, .u_i(u), .v_i(v),
    .sts_o(sts), .res_o(res), .rem_o(rem)
  );

  assign p3 = (p_i == FieldBits'(3)) ? '0 : FieldBits'(3);

  always_comb begin
    st_d = st_q; wait_d = wait_q; phase_d = phase_q;
    ca_d = ca_q; ax_d = ax_q; ay_d = ay_q; rx_d = rx_q; ry_d = ry_q;
    ainf_d = ainf_q; rinf_d = rinf_q; k_d = k_q;
    sx_d = sx_q; sy_d = sy_q; tx_d = tx_q; ty_d = ty_q;
    num_d = num_q; den_d = den_q; lam_d = lam_q; t0_d = t0_q; nx_d = nx_q;
    w0_d = w0_q; w1_d = w1_q; w2_d = w2_q; w3_d = w3_q; qq_d = qq_q; rr_d = rr_q;
    ctl.start = 1'b0; ctl.op = OP_ADD; u = '0; v = '0;
    go = !wait_q;
    case (st_q)
      S_IDLE: if (start_i) begin
        ainf_d = 1'b1; ax_d = '0; ay_d = '0; k_d = k_i;
        rx_d = x_i; ry_d = y_i; rinf_d = inf_i;
        st_d = (p_i < FieldBits'(3)) ? S_DONE : S_RA;
        wait_d = 1'b0;
      end
      S_RA, S_RX, S_RY: begin
        ctl.op = OP_MOD;
        u = (st_q == S_RA) ? {1'b0, a_i} : (st_q == S_RX) ? {1'b0, rx_q} : {1'b0, ry_q};
        if (go) begin ctl.start = 1'b1; wait_d = 1'b1; end
        else if (sts.done) begin
          wait_d = 1'b0;
          if (st_q == S_RA) begin ca_d = rem; st_d = S_RX; end
          else if (st_q == S_RX) begin rx_d = rem; st_d = S_RY; end
          else begin ry_d = rem; st_d = S_LOOP; end
        end
      end
      S_LOOP: st_d = (k_q == '0) ? S_DONE : S_SEL;
      S_SEL: begin
        if (phase_q == 1'b0 && k_q[0]) begin
          sx_d = ax_q; sy_d = ay_q; tx_d = rx_q; ty_d = ry_q;
          if (ainf_q) begin
            ax_d = rx_q; ay_d = ry_q; ainf_d = rinf_q; phase_d = 1'b1;
          end else if (rinf_q) begin
            phase_d = 1'b1;
          end else if (ax_q == rx_q && ay_q == ry_q) begin
            if (ay_q == '0) begin ainf_d = 1'b1; ax_d = '0; ay_d = '0; phase_d = 1'b1; end
            else st_d = S_DBL1;
          end else if (ax_q == rx_q) begin
            ainf_d = 1'b1; ax_d = '0; ay_d = '0; phase_d = 1'b1;
          end else st_d = S_ADD1;
        end else begin
          phase_d = 1'b1;
          sx_d = rx_q; sy_d = ry_q; tx_d = rx_q; ty_d = ry_q;
          if (phase_q == 1'b0) begin
            // no add this bit; fall into doubling
          end
          if (rinf_q) st_d = S_NEXT;
          else if (ry_q == '0) begin
            rinf_d = 1'b1; rx_d = '0; ry_d = '0; st_d = S_NEXT;
          end else st_d = S_DBL1;
        end
      end
      S_DBL1, S_DBL2, S_DBL3, S_DBL4, S_ADD1, S_ADD2, S_LAM, S_X1, S_X2, S_X3,
      S_Y1, S_Y2, S_Y3, S_INVQ, S_INVR, S_INVM, S_INVS: begin
        case (st_q)
          S_DBL1: begin ctl.op = OP_MUL; u = {1'b0, sx_q}; v = {1'b0, sx_q}; end
          S_DBL2: begin ctl.op = OP_MUL; u = {1'b0, p3}; v = {1'b0, t0_q}; end
          S_DBL3: begin ctl.op = OP_ADD; u = {1'b0, t0_q}; v = {1'b0, ca_q}; end
          S_DBL4: begin ctl.op = OP_ADD; u = {1'b0, sy_q}; v = {1'b0, sy_q}; end
          S_ADD1: begin ctl.op = OP_SUB; u = {1'b0, ty_q}; v = {1'b0, sy_q}; end
          S_ADD2: begin ctl.op = OP_SUB; u = {1'b0, tx_q}; v = {1'b0, sx_q}; end
          S_INVQ: begin ctl.op = OP_DIV; u = {1'b0, w0_q}; v = {1'b0, w1_q}; end
          S_INVR: begin ctl.op = OP_MOD; u = {1'b0, qq_q}; end
          S_INVM: begin ctl.op = OP_MUL; u = {1'b0, qq_q}; v = {1'b0, w3_q}; end
          S_INVS: begin ctl.op = OP_SUB; u = {1'b0, w2_q}; v = {1'b0, t0_q}; end
          S_LAM:  begin ctl.op = OP_MUL; u = {1'b0, num_q}; v = {1'b0, w2_q}; end
          S_X1:   begin ctl.op = OP_MUL; u = {1'b0, lam_q}; v = {1'b0, lam_q}; end
          S_X2:   begin ctl.op = OP_SUB; u = {1'b0, t0_q}; v = {1'b0, sx_q}; end
          S_X3:   begin ctl.op = OP_SUB; u = {1'b0, t0_q}; v = {1'b0, tx_q}; end
          S_Y1:   begin ctl.op = OP_SUB; u = {1'b0, sx_q}; v = {1'b0, nx_q}; end
          S_Y2:   begin ctl.op = OP_MUL; u = {1'b0, lam_q}; v = {1'b0, t0_q}; end
          default: begin ctl.op = OP_SUB; u = {1'b0, t0_q}; v = {1'b0, sy_q}; end
        endcase
        if (go) begin ctl.start = 1'b1; wait_d = 1'b1; end
        else if (sts.done) begin
          wait_d = 1'b0;
          case (st_q)
            S_DBL1: begin t0_d = res; st_d = S_DBL2; end
            S_DBL2: begin t0_d = res; st_d = S_DBL3; end
            S_DBL3: begin num_d = res; st_d = S_DBL4; end
            S_DBL4: begin den_d = res; st_d = S_INV0; end
            S_ADD1: begin num_d = res; st_d = S_ADD2; end
            S_ADD2: begin den_d = res; st_d = S_INV0; end
            S_INVQ: begin qq_d = res; rr_d = rem; st_d = S_INVR; end
            S_INVR: begin qq_d = rem; st_d = S_INVM; end
            S_INVM: begin t0_d = res; st_d = S_INVS; end
            S_INVS: begin
              w0_d = w1_q; w1_d = rr_q; w2_d = w3_q; w3_d = res;
              st_d = (rr_q == '0) ? S_LAM : S_INVQ;
            end
            S_LAM:  begin lam_d = res; st_d = S_X1; end
            S_X1:   begin t0_d = res; st_d = S_X2; end
            S_X2:   begin t0_d = res; st_d = S_X3; end
            S_X3:   begin nx_d = res; st_d = S_Y1; end
            S_Y1:   begin t0_d = res; st_d = S_Y2; end
            S_Y2:   begin t0_d = res; st_d = S_Y3; end
            default: begin t0_d = res; st_d = S_STORE; end
          endcase
        end
      end
      S_INV0: begin
        w0_d = p_i; w1_d = den_q; w2_d = '0;
        w3_d = (p_i == FieldBits'(1)) ? '0 : FieldBits'(1);
        st_d = (den_q == '0) ? S_LAM : S_INVQ;
        if (den_q == '0) w2_d = '0;
      end
      S_STORE: begin
        if (phase_q == 1'b0) begin
          ax_d = nx_q; ay_d = t0_q; ainf_d = 1'b0; phase_d = 1'b1; st_d = S_SEL;
        end else begin
          rx_d = nx_q; ry_d = t0_q; rinf_d = 1'b0; st_d = S_NEXT;
        end
      end
      S_NEXT: begin
        k_d = k_q >> 1; phase_d = 1'b0; st_d = S_LOOP;
      end
      S_DONE: if (ack_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      wait_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      st_q <= st_d;
      wait_q <= wait_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q <= ca_d; ax_q <= ax_d; ay_q <= ay_d; rx_q <= rx_d; ry_q <= ry_d;
    ainf_q <= ainf_d; rinf_q <= rinf_d; k_q <= k_d;
    sx_q <= sx_d; sy_q <= sy_d; tx_q <= tx_d; ty_q <= ty_d;
    num_q <= num_d; den_q <= den_d; lam_q <= lam_d; t0_q <= t0_d; nx_q <= nx_d;
    w0_q <= w0_d; w1_q <= w1_d; w2_q <= w2_d; w3_q <= w3_d; qq_q <= qq_d; rr_q <= rr_d;
  end

  assign busy_o = (st_q != S_IDLE);
  assign done_o = (st_q == S_DONE);
  assign x_o    = ainf_q ? '0 : ax_q;
  assign y_o    = ainf_q ? '0 : ay_q;
  assign inf_o  = ainf_q;
endmodule

// File: rtl/core/ec_point_scalar_multiply.sv
// Channel | dir | handshake        | payload
// in      | in  | in_valid_i/ready | base_x_i, base_y_i, base_is_infinity_i, scalar_i
// out     | out | out_valid_o/ready| result_x_o, result_y_o, result_is_infinity_o
// cfg     | in  | APB psel/penable | field_modulus, curve_coef_a
// Multiply, divide and reduce are long ops run bit-serially on the shared unit; add and
// subtract are short. A transaction starts with three reductions; a doubling then needs 5
// long ops, an addition 3, each plus 3 long ops per Euclid step of its inverse, and
// up to 64 point ops dominate. in_ready_o is low while the sequencer runs; a finished
// result waits there until the output register is free.
// Reset clears control; registers return to p=23, a=1.
// Depends on ecsm_pkg, ecsm_seq, ecsm_alu.
module ec_point_scalar_multiply (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ecsm_pkg::fe_t                    base_x_i,
  input  ecsm_pkg::fe_t                    base_y_i,
  input  logic                             base_is_infinity_i,
  input  logic [ecsm_pkg::ScalarBits-1:0]  scalar_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ecsm_pkg::fe_t                    result_x_o,
  output ecsm_pkg::fe_t                    result_y_o,
  output logic                             result_is_infinity_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ecsm_pkg::*;

  fe_t  p_q, a_q, rx_q, ry_q;
  logic rinf_q, ov_q;
  logic busy, done, sinf;
  fe_t  sx, sy;
  logic start;
  logic out_free;

  assign pready = 1'b1;
  assign start = in_valid_i && in_ready_o;
  assign in_ready_o = !busy;
  assign out_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= FieldBits'(23);
      a_q <= FieldBits'(1);
      ov_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr)
          RegModulus: p_q <= pwdata[FieldBits-1:0];
          RegCoefA:   a_q <= pwdata[FieldBits-1:0];
          default: ;
        endcase
      end
      if (done && out_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      rx_q <= sx; ry_q <= sy; rinf_q <= sinf;
    end
  end

  always_comb begin
    case (paddr)
      RegModulus: prdata = {1'b0, p_q};
      RegCoefA:   prdata = {1'b0, a_q};
      default:    prdata = '0;
    endcase
  end

  ecsm_seq u_seq (
    .clk_i, .rst_ni, .start_i(start), .ack_i(out_free), .p_i(p_q), .a_i(a_q),
    .x_i(base_x_i), .y_i(base_y_i), .inf_i(base_is_infinity_i), .k_i(scalar_i),
    .busy_o(busy), .done_o(done), .x_o(sx), .y_o(sy), .inf_o(sinf)
  );

  assign out_valid_o = ov_q;
  assign result_x_o = rx_q;
  assign result_y_o = ry_q;
  assign result_is_infinity_o = rinf_q;
endmodule

// File: rtl/core/ecsm_checker.sv
// ecsm_checker: port-level assertions for ec_point_scalar_multiply.
// Depends on ecsm_pkg; bound to the top level below.
module ecsm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic result_is_infinity_o,
  input ecsm_pkg::fe_t result_x_o,
  input ecsm_pkg::fe_t result_y_o
);
  import ecsm_pkg::*;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(result_x_o))
    else $error("result dropped");
  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_is_infinity_o) |-> (result_x_o == '0 && result_y_o == '0))
    else $error("infinity with coords");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(result_y_o) && $stable(result_is_infinity_o)))
    else $error("result changed while waiting");
endmodule

bind ec_point_scalar_multiply ecsm_checker u_ecsm_checker (.*);
